// ===== rtl/flrp_pkg.sv =====
package flrp_pkg;

    // Fixed field widths
    localparam int RCV_W = 16;
    localparam int OUT_W = 17;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;     // store one incoming cell
        logic begin_w;  // start the walk at cell 0
        logic advance;  // move to the next origin cell
        logic push;     // push current cell, follow its receiver
        logic settle;   // walk ended: fix the length of the end cell
        logic pop;      // assign one length back along the path
        logic finish;   // issue the result, clear for the next graph
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic stop;         // walk from current cell ends here
        logic depth_nz;     // path stack not empty
        logic origin_last;  // current origin is the final cell
    } t_stat;

endpackage

// ===== rtl/forest_longest_root_path_top.sv =====
// Loading: one cell per cycle; start is taken whenever busy is low.
// After the cell marked last, busy stays high for the memoized walk: a setup
// step, then per origin cell a push for each path cell, a settle, a pop for
// each pushed cell and an advance or finish step (single read port per RAM).
// o_valid pulses with o_longest as busy drops; the receiver cannot stall.
// Synchronous active-low reset clears the cell count, state and strobe.
module forest_longest_root_path_top import flrp_pkg::*; #(
    parameter int MAX_CELLS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [RCV_W-1:0] i_receiver,
    input  logic             i_last,
    output logic [OUT_W-1:0] o_longest,
    output logic             o_valid
);

    t_cmd  cmd;
    t_stat stat;

    flrp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    flrp_datapath #(.MAX_CELLS(MAX_CELLS)) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_receiver (i_receiver),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_longest  (o_longest),
        .o_valid    (o_valid)
    );

endmodule

// ===== rtl/flrp_ram.sv =====
module flrp_ram #(
    parameter int W = 16,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/flrp_ctrl.sv =====
module flrp_ctrl import flrp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_last,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.begin_w = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                if (i_stat.stop) begin
                    o_cmd.settle = 1'b1;
                    n_state      = i_stat.depth_nz ? S_POP : S_NEXT;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                if (!i_stat.depth_nz) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_stat.origin_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/flrp_datapath.sv =====
module flrp_datapath import flrp_pkg::*; #(
    parameter int MAX_CELLS = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [RCV_W-1:0] i_receiver,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic [OUT_W-1:0] o_longest,
    output logic             o_valid
);

    localparam int IW  = $clog2(MAX_CELLS);
    localparam int CW  = $clog2(MAX_CELLS + 1);
    localparam int LW0 = $clog2(MAX_CELLS + 2);
    localparam int LW  = (LW0 > OUT_W) ? LW0 : OUT_W;
    localparam int XW  = (CW > RCV_W) ? CW : RCV_W;

    logic [CW-1:0]    r_count;
    logic [IW-1:0]    r_origin;
    logic [IW-1:0]    r_cur;
    logic [CW-1:0]    r_depth;
    logic [LW-1:0]    r_val;
    logic [LW-1:0]    r_best;
    logic             r_valid;
    logic [OUT_W-1:0] r_longest;

    logic [RCV_W-1:0] rcv_q;
    logic [LW-1:0]    len_q;
    logic [IW-1:0]    stk_q;

    logic             full;
    logic             in_range;
    logic [IW-1:0]    rcv_idx;
    logic [LW-1:0]    value;
    logic [LW-1:0]    pop_val;
    logic [IW-1:0]    origin_nxt;
    logic             stk_rd;

    logic             cl_re;
    logic [IW-1:0]    cl_raddr;
    logic             len_we;
    logic [IW-1:0]    len_waddr;
    logic [LW-1:0]    len_wdata;
    logic             ld_we;

    // Cell status decode
    assign full       = (r_count == CW'(MAX_CELLS));
    assign in_range   = (XW'(rcv_q) < XW'(r_count));
    assign rcv_idx    = IW'(rcv_q);
    assign value      = (len_q != '0) ? len_q : LW'(1);
    assign pop_val    = r_val + LW'(1);
    assign origin_nxt = r_origin + IW'(1);
    assign stk_rd     = (i_cmd.settle | i_cmd.pop) & o_stat.depth_nz;
    assign ld_we      = i_cmd.load & ~full;

    assign o_stat.stop        = (len_q != '0) || !in_range || (rcv_idx == r_cur)
                                || (r_depth == r_count);
    assign o_stat.depth_nz    = (r_depth != '0);
    assign o_stat.origin_last = ((CW'(r_origin) + CW'(1)) == r_count);

    // Read address for receiver and length stores
    always_comb begin
        cl_re    = i_cmd.begin_w | i_cmd.advance | i_cmd.push;
        cl_raddr = '0;
        if (i_cmd.advance) begin
            cl_raddr = origin_nxt;
        end else if (i_cmd.push) begin
            cl_raddr = rcv_idx;
        end
    end

    // Length store write: clear on load, set on settle and pop
    always_comb begin
        len_we    = 1'b0;
        len_waddr = IW'(r_count);
        len_wdata = '0;
        if (ld_we) begin
            len_we = 1'b1;
        end else if (i_cmd.settle) begin
            len_we    = 1'b1;
            len_waddr = r_cur;
            len_wdata = value;
        end else if (i_cmd.pop) begin
            len_we    = 1'b1;
            len_waddr = stk_q;
            len_wdata = pop_val;
        end
    end

    flrp_ram #(.W(RCV_W), .D(MAX_CELLS)) u_rcv_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (IW'(r_count)),
        .i_wdata (i_receiver),
        .i_re    (cl_re),
        .i_raddr (cl_raddr),
        .o_rdata (rcv_q)
    );

    flrp_ram #(.W(LW), .D(MAX_CELLS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (cl_re),
        .i_raddr (cl_raddr),
        .o_rdata (len_q)
    );

    flrp_ram #(.W(IW), .D(MAX_CELLS)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (IW'(r_depth)),
        .i_wdata (r_cur),
        .i_re    (stk_rd),
        .i_raddr (IW'(r_depth - CW'(1))),
        .o_rdata (stk_q)
    );

    // Control counters and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_count <= '0;
            end else if (ld_we) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_w) begin
            r_origin <= '0;
            r_cur    <= '0;
            r_depth  <= '0;
            r_best   <= '0;
        end
        if (i_cmd.advance) begin
            r_origin <= origin_nxt;
            r_cur    <= origin_nxt;
            r_depth  <= '0;
        end
        if (i_cmd.push) begin
            r_cur   <= rcv_idx;
            r_depth <= r_depth + CW'(1);
        end
        if (stk_rd) begin
            r_depth <= r_depth - CW'(1);
        end
        if (i_cmd.settle) begin
            r_val <= value;
        end
        if (i_cmd.pop) begin
            r_val <= pop_val;
            if (pop_val > r_best) begin
                r_best <= pop_val;
            end
        end
        if (i_cmd.finish) begin
            r_longest <= r_best[OUT_W-1:0];
        end
    end

    assign o_longest = r_longest;
    assign o_valid   = r_valid;

endmodule
